// File: rtl/rsi_pkg.sv
package rsi_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_CENTER_X  = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y  = 2'd1;
  localparam logic [1:0] CFG_CENTER_Z  = 2'd2;
  localparam logic [1:0] CFG_RADIUS_SQ = 2'd3;

  // Result codes carried on the output tuser
  localparam logic [1:0] KIND_MISS    = 2'd0;
  localparam logic [1:0] KIND_OUTSIDE = 2'd1;
  localparam logic [1:0] KIND_INSIDE  = 2'd2;

  // Square root datapath: radicand, root and partial remainder widths
  localparam int ROOT_W = 52;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // b in 2^-32 units and distances in Q15.16
  localparam int B_W    = 53;
  localparam int DIST_W = 31;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [62:0] radius_squared;
  } cfg_t;

  // Per-ray data that rides alongside the square root
  typedef struct packed {
    logic [B_W-1:0]    b;
    logic [DIST_W-1:0] distance;
    logic              det_pos;
  } side_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

// File: rtl/rsi_front.sv
module rsi_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rsi_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  input  logic signed [31:0]         origin_x,
  input  logic signed [31:0]         origin_y,
  input  logic signed [31:0]         origin_z,
  input  logic signed [17:0]         dir_x,
  input  logic signed [17:0]         dir_y,
  input  logic signed [17:0]         dir_z,
  input  logic [30:0]                nearest_so_far,
  output logic                       out_valid,
  output rsi_pkg::side_t             out_side,
  output logic [rsi_pkg::RAD_W-1:0]  out_rad
);

  // valid bits of stages 1 to 7
  logic [6:0] vld;

  // stage 1: offset from center
  logic signed [32:0] vx_s1, vy_s1, vz_s1;
  logic signed [17:0] dx_s1, dy_s1, dz_s1;
  logic [30:0]        dist_s1;
  // stage 2: products
  logic signed [50:0] px_s2, py_s2, pz_s2;
  logic [64:0]        qx_s2, qy_s2, qz_s2;
  logic [30:0]        dist_s2;
  // stage 3: sums
  logic signed [52:0] dot_s3;
  logic [66:0]        vv_s3;
  logic [30:0]        dist_s3;
  // stage 4: b, |b| and r^2 - v.v
  logic [52:0]        b_s4;
  logic [51:0]        mag_s4;
  logic [67:0]        rv_s4;
  logic [30:0]        dist_s4;
  // stage 5: partial products of b^2
  logic [51:0]        hh_s5, hl_s5, ll_s5;
  logic [52:0]        b_s5;
  logic [67:0]        rv_s5;
  logic [30:0]        dist_s5;
  // stage 6: b^2
  logic [103:0]       bsq_s6;
  logic [52:0]        b_s6;
  logic [67:0]        rv_s6;
  logic [30:0]        dist_s6;
  // stage 7: discriminant
  logic [103:0]       rad_s7;
  logic [52:0]        b_s7;
  logic [30:0]        dist_s7;
  logic               pos_s7;

  logic signed [65:0] sqx_w, sqy_w, sqz_w;
  logic signed [52:0] neg_w;
  logic [105:0]       det_w;
  logic               pos_w;

  assign sqx_w = 66'(vx_s1) * 66'(vx_s1);
  assign sqy_w = 66'(vy_s1) * 66'(vy_s1);
  assign sqz_w = 66'(vz_s1) * 66'(vz_s1);
  assign neg_w = -dot_s3;

  // det = b^2 + (r^2 - v.v) * 2^32, positive values only go on to the root
  assign det_w = {2'b00, bsq_s6} + {{6{rv_s6[67]}}, rv_s6, 32'b0};
  assign pos_w = !det_w[105] && (det_w != '0);

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      vx_s1   <= 33'(origin_x) - 33'($signed(cfg.center_x));
      vy_s1   <= 33'(origin_y) - 33'($signed(cfg.center_y));
      vz_s1   <= 33'(origin_z) - 33'($signed(cfg.center_z));
      dx_s1   <= dir_x;
      dy_s1   <= dir_y;
      dz_s1   <= dir_z;
      dist_s1 <= nearest_so_far;

      px_s2   <= 51'(vx_s1) * 51'(dx_s1);
      py_s2   <= 51'(vy_s1) * 51'(dy_s1);
      pz_s2   <= 51'(vz_s1) * 51'(dz_s1);
      qx_s2   <= sqx_w[64:0];
      qy_s2   <= sqy_w[64:0];
      qz_s2   <= sqz_w[64:0];
      dist_s2 <= dist_s1;

      dot_s3  <= 53'(px_s2) + 53'(py_s2) + 53'(pz_s2);
      vv_s3   <= 67'(qx_s2) + 67'(qy_s2) + 67'(qz_s2);
      dist_s3 <= dist_s2;

      b_s4    <= neg_w;
      mag_s4  <= dot_s3[52] ? neg_w[51:0] : dot_s3[51:0];
      rv_s4   <= {5'b0, cfg.radius_squared} - {1'b0, vv_s3};
      dist_s4 <= dist_s3;

      hh_s5   <= 52'(mag_s4[51:26]) * 52'(mag_s4[51:26]);
      hl_s5   <= 52'(mag_s4[51:26]) * 52'(mag_s4[25:0]);
      ll_s5   <= 52'(mag_s4[25:0]) * 52'(mag_s4[25:0]);
      b_s5    <= b_s4;
      rv_s5   <= rv_s4;
      dist_s5 <= dist_s4;

      bsq_s6  <= {hh_s5, 52'b0} + {25'b0, hl_s5, 27'b0} + {52'b0, ll_s5};
      b_s6    <= b_s5;
      rv_s6   <= rv_s5;
      dist_s6 <= dist_s5;

      rad_s7  <= pos_w ? det_w[103:0] : '0;
      pos_s7  <= pos_w;
      b_s7    <= b_s6;
      dist_s7 <= dist_s6;
    end
  end

  assign out_valid = vld[6];
  assign out_side  = {b_s7, dist_s7, pos_s7};
  assign out_rad   = rad_s7;

endmodule

// File: rtl/rsi_sqrt.sv
module rsi_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  rsi_pkg::side_t              in_side,
  input  logic [rsi_pkg::RAD_W-1:0]   in_rad,
  output logic                        out_valid,
  output rsi_pkg::side_t              out_side,
  output logic [rsi_pkg::ROOT_W-1:0]  out_root
);

  localparam int N = rsi_pkg::ROOT_W;

  logic                       vld  [N];
  logic [rsi_pkg::REM_W-1:0]  rem  [N];
  logic [rsi_pkg::ROOT_W-1:0] root [N];
  logic [rsi_pkg::RAD_W-1:0]  rad  [N];
  rsi_pkg::side_t             side [N];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       vld_i;
    logic [rsi_pkg::REM_W-1:0]  rem_i;
    logic [rsi_pkg::ROOT_W-1:0] root_i;
    logic [rsi_pkg::RAD_W-1:0]  rad_i;
    rsi_pkg::side_t             side_i;
    logic [rsi_pkg::REM_W+1:0]  cur;
    logic [rsi_pkg::REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign rad_i  = rad[k-1];
      assign side_i = side[k-1];
    end

    assign cur   = {rem_i, rad_i[rsi_pkg::RAD_W-1 -: 2]};
    assign trial = cur - {2'b00, root_i, 2'b01};

    // advance valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    // keep the trial remainder when it does not go negative
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= trial[rsi_pkg::REM_W+1] ? cur[rsi_pkg::REM_W-1:0]
                                           : trial[rsi_pkg::REM_W-1:0];
        root[k] <= {root_i[rsi_pkg::ROOT_W-2:0], ~trial[rsi_pkg::REM_W+1]};
        rad[k]  <= {rad_i[rsi_pkg::RAD_W-3:0], 2'b00};
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_side  = side[N-1];
  assign out_root  = root[N-1];

endmodule

// File: rtl/rsi_pick.sv
module rsi_pick (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  rsi_pkg::side_t              in_side,
  input  logic [rsi_pkg::ROOT_W-1:0]  in_root,
  output logic                        out_valid,
  output rsi_pkg::res_t               out_res
);

  logic               vld_a;
  logic               vld_b;
  logic signed [53:0] near_a;
  logic signed [53:0] far_a;
  rsi_pkg::side_t     side_a;
  rsi_pkg::res_t      res_b;

  logic signed [53:0] b_w;
  logic signed [53:0] s_w;
  logic signed [53:0] limit;
  logic signed [53:0] pick;
  logic               far_pos;
  logic [1:0]         kind;
  logic [30:0]        newd;

  assign b_w = $signed({in_side.b[rsi_pkg::B_W-1], in_side.b});
  assign s_w = $signed({2'b00, in_root});

  // choose the crossing that is nearer than the incoming distance
  always_comb begin
    limit   = $signed({7'b0, side_a.distance, 16'b0});
    far_pos = !far_a[53] && (far_a != '0);
    kind    = rsi_pkg::KIND_MISS;
    pick    = '0;
    if (side_a.det_pos && far_pos) begin
      if (near_a[53]) begin
        if (far_a < limit) begin
          kind = rsi_pkg::KIND_INSIDE;
          pick = far_a;
        end
      end else if (near_a < limit) begin
        kind = rsi_pkg::KIND_OUTSIDE;
        pick = near_a;
      end
    end
    if (kind == rsi_pkg::KIND_MISS) begin
      newd = side_a.distance;
    end else if (pick[53:47] != '0) begin
      newd = '1;
    end else begin
      newd = pick[46:16];
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else if (en) begin
      vld_a <= in_valid;
      vld_b <= vld_a;
    end
  end

  // form near and far, then the result
  always_ff @(posedge clk) begin
    if (en) begin
      near_a <= b_w - s_w;
      far_a  <= b_w + s_w;
      side_a <= in_side;
      res_b  <= {kind, newd};
    end
  end

  assign out_valid = vld_b;
  assign out_res   = res_b;

endmodule

// File: rtl/rsi_obuf.sv
module rsi_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsi_pkg::res_t  push_res,
  input  logic           pop_ready,
  output logic           out_valid,
  output rsi_pkg::res_t  out_res,
  output logic           full
);

  rsi_pkg::res_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign out_valid = (count != 2'd0);
  assign out_res   = mem[rd_ptr];
  assign full      = (count == 2'd2);
  assign pop       = out_valid && pop_ready;

  // track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // store the incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

endmodule

// File: rtl/ray_sphere_intersect.sv
// Ray against sphere test, one ray per beat.
//
// Input beats on s_tvalid/s_tready/s_tdata carry a ray origin, a unit direction
// and the nearest hit distance so far. Every input beat gives exactly one output
// beat on m_tvalid/m_tready/m_tdata/m_tuser: the hit kind (miss, hit from
// outside, hit from inside) and the updated nearest distance, in input order.
// The sphere center and squared radius are set through cfg_we/cfg_index/cfg_data
// by the user, only while no ray is in flight; the block does not enforce this.
//
// The pipeline has seven stages for the offset, dot products and discriminant,
// one stage per root bit in the 52-stage square root, two stages to pick near
// or far and one in the output buffer. One ray enters every cycle while the
// receiver keeps up.
//
// Reset clears the configuration registers to zero and empties the pipeline.
// A two-entry output buffer holds results; s_tready drops only when it is full,
// and the whole pipeline then holds until the receiver takes a beat.
module ray_sphere_intersect (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x[31:0], origin_y[63:32], origin_z[95:64], dir_x[113:96],
  // dir_y[131:114], dir_z[149:132], nearest_so_far[180:150], zero pad
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_distance[30:0], zero pad
  output logic [31:0]  m_tdata,
  // hit_kind[1:0]
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [62:0]  cfg_data
);

  rsi_pkg::cfg_t  cfg;
  logic           en;
  logic           full;

  logic           front_valid;
  rsi_pkg::side_t front_side;
  logic [rsi_pkg::RAD_W-1:0]  front_rad;

  logic           root_valid;
  rsi_pkg::side_t root_side;
  logic [rsi_pkg::ROOT_W-1:0] root_val;

  logic           pick_valid;
  rsi_pkg::res_t  pick_res;
  rsi_pkg::res_t  head_res;
  logic           push;

  // hold the whole pipeline only while the output buffer is full
  assign en       = !full;
  assign s_tready = en;
  assign push     = en && pick_valid;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsi_pkg::CFG_CENTER_X:  cfg.center_x       <= cfg_data[31:0];
        rsi_pkg::CFG_CENTER_Y:  cfg.center_y       <= cfg_data[31:0];
        rsi_pkg::CFG_CENTER_Z:  cfg.center_z       <= cfg_data[31:0];
        rsi_pkg::CFG_RADIUS_SQ: cfg.radius_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .origin_x       ($signed(s_tdata[31:0])),
    .origin_y       ($signed(s_tdata[63:32])),
    .origin_z       ($signed(s_tdata[95:64])),
    .dir_x          ($signed(s_tdata[113:96])),
    .dir_y          ($signed(s_tdata[131:114])),
    .dir_z          ($signed(s_tdata[149:132])),
    .nearest_so_far (s_tdata[180:150]),
    .out_valid      (front_valid),
    .out_side       (front_side),
    .out_rad        (front_rad)
  );

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_side   (front_side),
    .in_rad    (front_rad),
    .out_valid (root_valid),
    .out_side  (root_side),
    .out_root  (root_val)
  );

  rsi_pick u_pick (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_side   (root_side),
    .in_root   (root_val),
    .out_valid (pick_valid),
    .out_res   (pick_res)
  );

  rsi_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (pick_res),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (head_res),
    .full      (full)
  );

  assign m_tdata = {1'b0, head_res.distance};
  assign m_tuser = head_res.kind;

  // a result pushed into an empty buffer shows on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && !m_tvalid) |=> m_tvalid)
    else $error("pushed result did not reach the output");

  // input is held off only while a result waits at the output
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  // the result code is one of the three defined kinds
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == rsi_pkg::KIND_MISS || m_tuser == rsi_pkg::KIND_OUTSIDE ||
                  m_tuser == rsi_pkg::KIND_INSIDE))
    else $error("undefined hit kind on output");

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// File: dv/ray_sphere_checker.sv
`timescale 1ns / 100ps

module ray_sphere_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // origin_x[31:0], origin_y[63:32], origin_z[95:64], dir_x[113:96],
  // dir_y[131:114], dir_z[149:132], nearest_so_far[180:150], zero pad
  input  logic [183:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // new_distance[30:0], zero pad
  input  logic [31:0]  m_tdata,
  // hit_kind[1:0]
  input  logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  output int           bad_results,
  output int           open_hits
);

  // Local copy of the sphere registers
  logic signed [31:0] sph_cx;
  logic signed [31:0] sph_cy;
  logic signed [31:0] sph_cz;
  logic [62:0]        sph_r2;

  rsi_pkg::res_t expected_hits[$];
  rsi_pkg::res_t want;
  rsi_pkg::res_t got;

  // Exact ray/sphere test on one input beat, at full width
  function automatic rsi_pkg::res_t sphere_hit(input logic [183:0] beat);
    logic signed [31:0]  ox, oy, oz;
    logic signed [17:0]  dx, dy, dz;
    logic [30:0]         distance;
    logic signed [127:0] vx, vy, vz, b, vv, rr, det, s_w, near_t, far_t, limit;
    logic [127:0]        rad;
    logic [63:0]         root, trial;
    int                  i;
    rsi_pkg::res_t       res;
    ox   = beat[31:0];
    oy   = beat[63:32];
    oz   = beat[95:64];
    dx   = beat[113:96];
    dy   = beat[131:114];
    dz   = beat[149:132];
    distance = beat[180:150];
    vx = ox - sph_cx;
    vy = oy - sph_cy;
    vz = oz - sph_cz;
    b  = -(vx * dx + vy * dy + vz * dz);
    vv = vx * vx + vy * vy + vz * vz;
    rr = {65'd0, sph_r2};
    det = b * b - (vv <<< 32) + (rr <<< 32);
    res.kind = rsi_pkg::KIND_MISS;
    res.distance = distance;
    if (det > 0) begin
      // floor of the square root, one bit at a time
      rad  = det;
      root = '0;
      for (i = 63; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if ({64'd0, trial} * {64'd0, trial} <= rad)
          root = trial;
      end
      s_w    = {64'd0, root};
      near_t = b - s_w;
      far_t  = b + s_w;
      limit  = {81'd0, distance, 16'd0};
      if (far_t > 0) begin
        if (near_t < 0) begin
          if (far_t < limit) begin
            res.kind = rsi_pkg::KIND_INSIDE;
            res.distance = far_t[46:16];
          end
        end else if (near_t < limit) begin
          res.kind = rsi_pkg::KIND_OUTSIDE;
          res.distance = near_t[46:16];
        end
      end
    end
    return res;
  endfunction

  // Predict on input beats, compare on output beats, track register writes
  always @(posedge clk) begin
    if (rst) begin
      sph_cx <= '0;
      sph_cy <= '0;
      sph_cz <= '0;
      sph_r2 <= '0;
      expected_hits.delete();
      bad_results = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_hits.push_back(sphere_hit(s_tdata));
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.distance = m_tdata[30:0];
        if (expected_hits.size() == 0) begin
          if (bad_results < 10)
            $display("%0t: result beat with nothing expected: kind %0d dist %h",
                     $realtime, got.kind, got.distance);
          bad_results++;
        end else begin
          want = expected_hits.pop_front();
          if (got.kind !== want.kind || got.distance !== want.distance) begin
            if (bad_results < 10)
              $display("%0t: mismatch: kind exp %0d got %0d, dist exp %h got %h",
                       $realtime, want.kind, got.kind, want.distance, got.distance);
            bad_results++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rsi_pkg::CFG_CENTER_X:  sph_cx <= cfg_data[31:0];
          rsi_pkg::CFG_CENTER_Y:  sph_cy <= cfg_data[31:0];
          rsi_pkg::CFG_CENTER_Z:  sph_cz <= cfg_data[31:0];
          rsi_pkg::CFG_RADIUS_SQ: sph_r2 <= cfg_data;
          default: ;
        endcase
      end
    end
    open_hits = expected_hits.size();
  end

endmodule

// File: dv/ray_sphere_intersect_tb.sv
`timescale 1ns / 100ps

module ray_sphere_intersect_tb;

  typedef struct {
    logic [31:0] ox, oy, oz;
    logic [17:0] dx, dy, dz;
    logic [30:0] distance;
  } ray_t;

  typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_CYCLE} rx_mode_t;

  localparam logic [17:0] ONE      = 18'h10000;
  localparam logic [17:0] NEG_ONE  = 18'h30000;
  localparam logic [17:0] DIR_MAX  = 18'h1FFFF;
  localparam logic [17:0] DIR_MIN  = 18'h20000;
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam longint      O_MAX    = 64'sd2147483647;
  localparam longint      O_MIN    = -64'sd2147483648;
  localparam longint      SPAN_CAP = 64'sd536870912;
  localparam int          LONG_HOLD = 400;
  localparam int          PHASE_RAYS = 235;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [183:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [62:0]  cfg_data = '0;

  int bad_count;
  int open_count;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_tick = 0;
  logic     hold_req = 1'b0;
  int       gap_max = 0;
  int       burst_left = 0;
  longint   sph_c[3];
  longint   sph_rad;

  ray_sphere_intersect dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ray_sphere_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bad_results(bad_count),
    .open_hits  (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q16.16 from a whole number
  function automatic logic [31:0] fx(input int whole);
    return whole * 65536;
  endfunction

  function automatic longint rand_span(input longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_t mk_ray(input logic [31:0] ox, oy, oz,
                                  input logic [17:0] dx, dy, dz,
                                  input logic [30:0] distance);
    ray_t r;
    r.ox = ox;
    r.oy = oy;
    r.oz = oz;
    r.dx = dx;
    r.dy = dy;
    r.dz = dz;
    r.distance = distance;
    return r;
  endfunction

  // Any bit pattern in every field, direction not normalized
  function automatic ray_t noise_ray();
    return mk_ray($urandom, $urandom, $urandom, 18'($urandom), 18'($urandom),
                  18'($urandom), 31'($urandom));
  endfunction

  // Ray from near the sphere, pointed at a point inside or close to it
  function automatic ray_t aimed_ray();
    longint      span, jit, o[3], t[3];
    real         w[3], len, cap_r;
    int unsigned cap;
    int          i;
    ray_t        r;
    span = sph_rad * 4 + 65536;
    if (span > SPAN_CAP) span = SPAN_CAP;
    jit = sph_rad;
    if (jit > SPAN_CAP) jit = SPAN_CAP;
    for (i = 0; i < 3; i++) begin
      o[i] = sph_c[i] + rand_span(span);
      if (o[i] > O_MAX) o[i] = O_MAX;
      if (o[i] < O_MIN) o[i] = O_MIN;
      t[i] = sph_c[i] + rand_span(jit);
      w[i] = real'(t[i] - o[i]);
    end
    r.ox = 32'(o[0]);
    r.oy = 32'(o[1]);
    r.oz = 32'(o[2]);
    len = $sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
    if (len < 1.0) begin
      r.dx = ONE;
      r.dy = '0;
      r.dz = '0;
    end else begin
      r.dx = 18'($rtoi(w[0] / len * 65536.0));
      r.dy = 18'($rtoi(w[1] / len * 65536.0));
      r.dz = 18'($rtoi(w[2] / len * 65536.0));
    end
    // turn some rays away from the sphere
    if ($urandom_range(0, 7) == 0) begin
      r.dx = -r.dx;
      r.dy = -r.dy;
      r.dz = -r.dz;
    end
    case ($urandom_range(0, 3))
      0, 1: r.distance = DIST_MAX;
      2: r.distance = 31'($urandom);
      default: begin
        cap_r = 2.0 * len;
        cap = (cap_r > 2147483647.0) ? 32'h7FFF_FFFF : $rtoi(cap_r);
        r.distance = 31'($urandom_range(0, cap));
      end
    endcase
    return r;
  endfunction

  // Offer one beat, in bursts with random gaps between them
  task automatic push_ray(input ray_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tdata <= {3'b0, r.distance, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and hold until every predicted result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [62:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_sphere(input logic [31:0] x, y, z, input logic [62:0] r2);
    write_reg(rsi_pkg::CFG_CENTER_X, {{31{x[31]}}, x});
    write_reg(rsi_pkg::CFG_CENTER_Y, {{31{y[31]}}, y});
    write_reg(rsi_pkg::CFG_CENTER_Z, {{31{z[31]}}, z});
    write_reg(rsi_pkg::CFG_RADIUS_SQ, r2);
    cfg_we <= 1'b0;
    sph_c[0] = $signed(x);
    sph_c[1] = $signed(y);
    sph_c[2] = $signed(z);
    sph_rad = longint'($sqrt(real'(r2)));
  endtask

  // Receiver: stall pattern per phase, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        rx_tick++;
        case (rx_mode)
          RX_FREE:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
          default:   m_tready <= ((rx_tick % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("ray_sphere_intersect_tb: FAIL");
    $finish;
  end

  initial begin
    int          ph, n, bits;
    longint      rad;
    logic [62:0] r2;
    sph_c[0] = 0;
    sph_c[1] = 0;
    sph_c[2] = 0;
    sph_rad = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: empty sphere at the origin, extreme fields
    push_ray(mk_ray(32'd0, 32'd0, 32'd0, 18'd0, 18'd0, 18'd0, 31'd0));
    push_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    DIR_MAX, DIR_MIN, DIR_MAX, DIST_MAX));
    push_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    DIR_MIN, DIR_MAX, DIR_MIN, 31'd0));
    push_ray(mk_ray(32'hFFFF_FFFF, 32'd0, 32'd1, ONE, 18'd0, NEG_ONE, DIST_MAX));
    drain_results();

    // Unit sphere at the origin: hits, near misses and the edge cases
    set_sphere(32'd0, 32'd0, 32'd0, 63'h1_0000_0000);
    push_ray(mk_ray(fx(-5), 32'd0, 32'd0, ONE, 18'd0, 18'd0, DIST_MAX));
    push_ray(mk_ray(fx(-5), 32'd0, 32'd0, ONE, 18'd0, 18'd0, 31'(fx(4))));
    push_ray(mk_ray(32'd0, 32'd0, 32'd0, ONE, 18'd0, 18'd0, DIST_MAX));
    push_ray(mk_ray(32'd0, 32'd0, 32'd0, ONE, 18'd0, 18'd0, 31'(fx(1))));
    // origin on the surface: near is exactly zero
    push_ray(mk_ray(fx(-1), 32'd0, 32'd0, ONE, 18'd0, 18'd0, DIST_MAX));
    // grazing ray: discriminant exactly zero
    push_ray(mk_ray(fx(-5), fx(1), 32'd0, ONE, 18'd0, 18'd0, DIST_MAX));
    // sphere behind the origin
    push_ray(mk_ray(fx(5), 32'd0, 32'd0, ONE, 18'd0, 18'd0, DIST_MAX));
    push_ray(mk_ray(fx(-5), 32'd0, 32'd0, NEG_ONE, 18'd0, 18'd0, DIST_MAX));
    // direction longer than one
    push_ray(mk_ray(fx(-5), 32'd0, 32'd0, DIR_MAX, 18'd0, 18'd0, DIST_MAX));
    push_ray(mk_ray(32'd0, fx(-3), 32'd0, 18'd0, ONE, 18'd0, 31'(fx(3))));
    drain_results();

    // Extreme center and the largest squared radius
    set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    push_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    DIR_MAX, DIR_MIN, DIR_MAX, DIST_MAX));
    push_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    ONE, 18'd0, 18'd0, DIST_MAX));
    push_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    18'd0, 18'd0, NEG_ONE, 31'd1));
    push_ray(mk_ray(32'd0, 32'd0, 32'd0, DIR_MIN, DIR_MIN, DIR_MIN, DIST_MAX));

    // Random phases: new sphere, receiver pattern and sender gaps each time
    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      if (ph == 7) begin
        r2 = 63'({$urandom, $urandom});
        set_sphere($urandom, $urandom, $urandom, r2);
      end else begin
        bits = 4 + 8 * (ph % 4);
        rad = longint'($urandom_range(1, 1 << bits));
        r2 = 63'(rad * rad);
        set_sphere(32'(rand_span(1 << 28)), 32'(rand_span(1 << 28)),
                   32'(rand_span(1 << 28)), r2);
      end
      rx_mode = rx_mode_t'(ph % 4);
      gap_max = (ph % 3 == 0) ? 0 : 4 * ph;
      if (ph == 2)
        hold_req = 1'b1;
      for (n = 0; n < PHASE_RAYS; n++) begin
        if ($urandom_range(0, 99) < ((ph == 7) ? 60 : 15))
          push_ray(noise_ray());
        else
          push_ray(aimed_ray());
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (bad_count == 0 && open_count == 0)
      $display("ray_sphere_intersect_tb: PASS");
    else
      $display("ray_sphere_intersect_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_sqrt.sv
rtl/rsi_pick.sv
rtl/rsi_obuf.sv
rtl/ray_sphere_intersect.sv
dv/ray_sphere_checker.sv
dv/ray_sphere_intersect_tb.sv
